/* sv/accumulator_calculator_with_history_core_assert.svh */
// Assertion macros shared by the accumulator calculator RTL.
`ifndef ACCUMULATOR_CALCULATOR_WITH_HISTORY_CORE_ASSERT_SVH
`define ACCUMULATOR_CALCULATOR_WITH_HISTORY_CORE_ASSERT_SVH
// Check cons in the same cycle as ante.
`define ACCH_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("acch assertion failed");
// Check cons in the cycle after ante.
`define ACCH_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("acch assertion failed");
`endif

/* sv/acch_pkg.sv */
// Shared types, codes and constants of the accumulator calculator.
package acch_pkg;

  localparam int unsigned ACCH_HIST_DEPTH = 10;
  localparam int unsigned Q_W = 64;

  localparam logic [3:0] ACT_SET    = 4'd0;
  localparam logic [3:0] ACT_EQUALS = 4'd1;
  localparam logic [3:0] ACT_ADD    = 4'd2;
  localparam logic [3:0] ACT_SUB    = 4'd3;
  localparam logic [3:0] ACT_MUL    = 4'd4;
  localparam logic [3:0] ACT_DIV    = 4'd5;
  localparam logic [3:0] ACT_NEG    = 4'd6;
  localparam logic [3:0] ACT_SQRT   = 4'd7;
  localparam logic [3:0] ACT_POW    = 4'd8;
  localparam logic [3:0] ACT_RECIP  = 4'd9;
  localparam logic [3:0] ACT_RECALL = 4'd10;
  localparam logic [3:0] ACT_CLEAR  = 4'd11;
  localparam logic [3:0] ACT_CLRH   = 4'd12;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DIV0      = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_SAT       = 3'd4;

  localparam logic [63:0] Q_ONE    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_TOP    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [63:0] operand;
    logic [3:0]         recall_index;
  } acch_in_t;

  typedef struct packed {
    logic signed [63:0] current_value;
    logic [2:0]         status;
    logic [3:0]         history_count;
  } acch_out_t;

  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_DIV,
    UOP_SQRT
  } uop_t;

  // MUL: (a*b)>>32, DIV: (a<<32)/b, SQRT: sqrt(a<<32); magnitudes only
  typedef struct packed {
    logic        start;
    uop_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } unit_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
    logic        ovf;
  } unit_resp_t;

endpackage

/* sv/acch_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module acch_ram #(
  parameter int unsigned WIDTH = acch_pkg::Q_W,
  parameter int unsigned DEPTH = acch_pkg::ACCH_HIST_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/acch_unit.sv */
// Shared bit-serial unit: Q32.32 multiply, divide and square root on magnitudes.
module acch_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  acch_pkg::unit_req_t    req,
  output acch_pkg::unit_resp_t   resp
);
  import acch_pkg::*;

  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] MUL_STEPS  = 7'd64;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd96;
  localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd48;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  uop_t             op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [65:0]      hi_r, hi_nxt;
  logic [63:0]      lo_r, lo_nxt;
  logic [63:0]      q_r, q_nxt;
  logic [63:0]      d_r, d_nxt;
  logic             big_r, big_nxt;

  logic [65:0] add_x, add_y, add_s;
  logic        add_sub;
  logic [65:0] rem2;
  logic [63:0] mul_res, fin_res;
  logic        fin_ovf;

  // the one adder/subtractor every operation shares
  assign add_s = add_x + (add_y ^ {66{add_sub}}) + {65'd0, add_sub};

  always_comb begin
    add_x    = '0;
    add_y    = '0;
    add_sub  = 1'b0;
    rem2     = '0;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    big_nxt  = big_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req.op;
        hi_nxt   = '0;
        q_nxt    = '0;
        big_nxt  = 1'b0;
        lo_nxt   = req.a;
        d_nxt    = req.b;
        case (req.op)
          UOP_MUL: begin
            // multiplier bits come from lo, multiplicand sits in d
            lo_nxt  = req.b;
            d_nxt   = req.a;
            cnt_nxt = MUL_STEPS;
          end
          UOP_DIV:  cnt_nxt = DIV_STEPS;
          UOP_SQRT: cnt_nxt = SQRT_STEPS;
          default:  cnt_nxt = MUL_STEPS;
        endcase
      end
    end else begin
      case (op_r)
        UOP_MUL: begin
          add_x  = {2'b00, hi_r[63:0]};
          add_y  = lo_r[0] ? {2'b00, d_r} : '0;
          hi_nxt = {2'b00, add_s[64:1]};
          lo_nxt = {add_s[0], lo_r[63:1]};
        end
        UOP_DIV: begin
          rem2    = {1'b0, hi_r[63:0], lo_r[63]};
          add_x   = rem2;
          add_y   = {2'b00, d_r};
          add_sub = 1'b1;
          big_nxt = big_r | q_r[63];
          if (!add_s[65]) begin
            hi_nxt = add_s;
            q_nxt  = {q_r[62:0], 1'b1};
          end else begin
            hi_nxt = rem2;
            q_nxt  = {q_r[62:0], 1'b0};
          end
          lo_nxt = {lo_r[62:0], 1'b0};
        end
        UOP_SQRT: begin
          rem2    = {hi_r[63:0], lo_r[63:62]};
          add_x   = rem2;
          add_y   = {16'd0, q_r[47:0], 2'b01};
          add_sub = 1'b1;
          if (!add_s[65]) begin
            hi_nxt = add_s;
            q_nxt  = {q_r[62:0], 1'b1};
          end else begin
            hi_nxt = rem2;
            q_nxt  = {q_r[62:0], 1'b0};
          end
          lo_nxt = {lo_r[61:0], 2'b00};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign mul_res = {hi_r[31:0], lo_r[63:32]};

  always_comb begin
    fin_ovf = 1'b0;
    fin_res = q_r;
    case (op_r)
      UOP_MUL: begin
        fin_ovf = (|hi_r[63:32]) || (mul_res > Q_TOP);
        fin_res = fin_ovf ? Q_TOP : mul_res;
      end
      UOP_DIV: begin
        fin_ovf = big_r || (q_r > Q_TOP);
        fin_res = fin_ovf ? Q_TOP : q_r;
      end
      UOP_SQRT: fin_res = {16'd0, q_r[47:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= UOP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    big_r <= big_nxt;
  end

  assign resp.busy = busy_r;
  assign resp.done = done_r;
  assign resp.res  = fin_res;
  assign resp.ovf  = fin_ovf;

endmodule

/* sv/accumulator_calculator_with_history_core.sv */
// Top level of the Q32.32 accumulator calculator with result history.
//
// Usage: one item on in_data (action, operand, recall_index) is taken when
// in_valid is high and in_stall is low; one item leaves on out_data
// (current_value, status, history_count) when out_valid is high and out_stall
// is low. in_stall stays high from acceptance until the result is loaded into
// the output register, so one item is in flight at a time.
// Set, equals, add, sub, negate, clear and clear history go from S_EXEC to
// S_FIN; recall adds S_RDWAIT for the history RAM read. Multiply, divide,
// reciprocal and square root run on the bit-serial shared unit (one bit, or
// two radicand bits, per cycle). Power runs square-and-multiply over the
// integer exponent bits and one root plus optional multiply per fraction bit.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and only loading its result waits for out_stall to drop.
// Reset clears the accumulator and the history fill; history entries are
// only read below the fill count, so the RAM needs no clearing pass.
`include "accumulator_calculator_with_history_core_assert.svh"
module accumulator_calculator_with_history_core #(
  parameter int unsigned HISTORY_DEPTH = acch_pkg::ACCH_HIST_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acch_pkg::acch_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acch_pkg::acch_out_t out_data
);
  import acch_pkg::*;

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = $clog2(2 * HISTORY_DEPTH);
  localparam int unsigned CW = (FW > 4) ? FW : 4;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_EXEC   = 11'b000_0000_0010,
    S_UNIT   = 11'b000_0000_0100,
    S_RDWAIT = 11'b000_0000_1000,
    S_PW_I0  = 11'b000_0001_0000,
    S_PW_I1  = 11'b000_0010_0000,
    S_PW_F0  = 11'b000_0100_0000,
    S_PW_F1  = 11'b000_1000_0000,
    S_PW_F2  = 11'b001_0000_0000,
    S_PW_E   = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  // what to do with the shared unit's result
  typedef enum logic [2:0] {
    TG_SIGNED,
    TG_SQRT,
    TG_PW_MI,
    TG_PW_SQ,
    TG_PW_RT,
    TG_PW_MF,
    TG_PW_RC
  } tag_t;

  state_t      state_r, state_nxt;
  tag_t        tag_r, tag_nxt;
  logic [3:0]  act_r, act_nxt;
  logic [63:0] opnd_r, opnd_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] res_r, res_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        push_r, push_nxt;
  logic        upd_r, upd_nxt;
  logic        clrh_r, clrh_nxt;
  logic        neg_r, neg_nxt;
  logic        big_r, big_nxt;
  logic        sqbig_r, sqbig_nxt;
  logic        eneg_r, eneg_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [63:0] sq_r, sq_nxt;
  logic [63:0] rt_r, rt_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic        out_valid_r, out_valid_nxt;
  acch_out_t   out_data_r, out_data_nxt;

  unit_req_t   ureq;
  unit_resp_t  uresp;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_rdata;

  logic [63:0] acc_mag, op_mag;
  logic [63:0] as_sum;
  logic        as_sub, as_ovf;
  logic [64:0] fix;
  logic [CW-1:0] cnt_ext;
  logic [63:0] fin_value;

  function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] x);
    logic [SW-1:0] y;
    y = (x >= SW'(HISTORY_DEPTH)) ? x - SW'(HISTORY_DEPTH) : x;
    return y[AW-1:0];
  endfunction

  // give a magnitude its sign; returns {saturated, value}
  function automatic logic [64:0] sign_fix(input logic [63:0] mag, input logic neg,
                                           input logic big);
    if (neg) begin
      if (big) begin
        return {1'b1, Q_TOP};
      end
      return {1'b0, 64'd0 - mag};
    end
    if (big || mag[63]) begin
      return {1'b1, Q_MAXPOS};
    end
    return {1'b0, mag};
  endfunction

  acch_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .resp  (uresp)
  );

  acch_ram #(
    .WIDTH (Q_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (res_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign acc_mag = acc_r[63] ? 64'd0 - acc_r : acc_r;
  assign op_mag  = opnd_r[63] ? 64'd0 - opnd_r : opnd_r;

  // single add/sub for add and subtract, with signed overflow check
  assign as_sub = (act_r == ACT_SUB);
  assign as_sum = acc_r + (opnd_r ^ {64{as_sub}}) + {63'd0, as_sub};
  assign as_ovf = ((acc_r[63] ^ opnd_r[63]) == as_sub) && (as_sum[63] != acc_r[63]);

  assign ram_raddr = wrap_addr(SW'(head_r) + SW'(idx_r));
  assign in_stall  = (state_r != S_IDLE);
  assign fin_value = (upd_r || push_r) ? res_r : acc_r;

  always_comb begin
    state_nxt     = state_r;
    tag_nxt       = tag_r;
    act_nxt       = act_r;
    opnd_nxt      = opnd_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    push_nxt      = push_r;
    upd_nxt       = upd_r;
    clrh_nxt      = clrh_r;
    neg_nxt       = neg_r;
    big_nxt       = big_r;
    sqbig_nxt     = sqbig_r;
    eneg_nxt      = eneg_r;
    mag_nxt       = mag_r;
    sq_nxt        = sq_r;
    rt_nxt        = rt_r;
    ip_nxt        = ip_r;
    frac_nxt      = frac_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ureq.start    = 1'b0;
    ureq.op       = UOP_MUL;
    ureq.a        = '0;
    ureq.b        = '0;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    fix           = '0;
    cnt_ext       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_data.action;
          opnd_nxt  = in_data.operand;
          idx_nxt   = in_data.recall_index;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        upd_nxt   = 1'b0;
        push_nxt  = 1'b0;
        clrh_nxt  = 1'b0;
        stat_nxt  = ST_OK;
        res_nxt   = acc_r;
        state_nxt = S_FIN;
        case (act_r)
          ACT_SET: begin
            res_nxt = opnd_r;
            upd_nxt = 1'b1;
          end
          ACT_EQUALS: push_nxt = 1'b1;
          ACT_ADD, ACT_SUB: begin
            push_nxt = 1'b1;
            if (as_ovf) begin
              res_nxt  = acc_r[63] ? Q_TOP : Q_MAXPOS;
              stat_nxt = ST_SAT;
            end else begin
              res_nxt = as_sum;
            end
          end
          ACT_MUL: begin
            ureq.start = 1'b1;
            ureq.op    = UOP_MUL;
            ureq.a     = acc_mag;
            ureq.b     = op_mag;
            neg_nxt    = acc_r[63] ^ opnd_r[63];
            tag_nxt    = TG_SIGNED;
            state_nxt  = S_UNIT;
          end
          ACT_DIV: begin
            if (opnd_r == 64'd0) begin
              stat_nxt = ST_DIV0;
            end else begin
              ureq.start = 1'b1;
              ureq.op    = UOP_DIV;
              ureq.a     = acc_mag;
              ureq.b     = op_mag;
              neg_nxt    = acc_r[63] ^ opnd_r[63];
              tag_nxt    = TG_SIGNED;
              state_nxt  = S_UNIT;
            end
          end
          ACT_NEG: begin
            push_nxt = 1'b1;
            if (acc_r == Q_TOP) begin
              res_nxt  = Q_MAXPOS;
              stat_nxt = ST_SAT;
            end else begin
              res_nxt = 64'd0 - acc_r;
            end
          end
          ACT_SQRT: begin
            if (acc_r[63]) begin
              stat_nxt = ST_INVALID;
            end else begin
              ureq.start = 1'b1;
              ureq.op    = UOP_SQRT;
              ureq.a     = acc_r;
              tag_nxt    = TG_SQRT;
              state_nxt  = S_UNIT;
            end
          end
          ACT_POW: begin
            if ((acc_r[63] && (op_mag[31:0] != 32'd0)) ||
                ((acc_r == 64'd0) && opnd_r[63])) begin
              stat_nxt = ST_INVALID;
            end else begin
              mag_nxt   = Q_ONE;
              sq_nxt    = acc_mag;
              rt_nxt    = acc_mag;
              big_nxt   = 1'b0;
              sqbig_nxt = 1'b0;
              ip_nxt    = op_mag[63:32];
              frac_nxt  = op_mag[31:0];
              eneg_nxt  = opnd_r[63];
              neg_nxt   = acc_r[63] & op_mag[32];
              state_nxt = S_PW_I0;
            end
          end
          ACT_RECIP: begin
            if (acc_r == 64'd0) begin
              stat_nxt = ST_DIV0;
            end else begin
              ureq.start = 1'b1;
              ureq.op    = UOP_DIV;
              ureq.a     = Q_ONE;
              ureq.b     = acc_mag;
              neg_nxt    = acc_r[63];
              tag_nxt    = TG_SIGNED;
              state_nxt  = S_UNIT;
            end
          end
          ACT_RECALL: begin
            // read issued now through ram_raddr, data lands next cycle
            if (CW'(idx_r) < CW'(fill_r)) begin
              upd_nxt   = 1'b1;
              state_nxt = S_RDWAIT;
            end else begin
              stat_nxt = ST_BAD_INDEX;
            end
          end
          ACT_CLEAR: begin
            res_nxt = 64'd0;
            upd_nxt = 1'b1;
          end
          ACT_CLRH: clrh_nxt = 1'b1;
          default: ;
        endcase
      end

      S_UNIT: begin
        if (uresp.done) begin
          case (tag_r)
            TG_SIGNED: begin
              fix       = sign_fix(uresp.res, neg_r && (uresp.res != 64'd0), uresp.ovf);
              res_nxt   = fix[63:0];
              stat_nxt  = fix[64] ? ST_SAT : ST_OK;
              push_nxt  = 1'b1;
              state_nxt = S_FIN;
            end
            TG_SQRT: begin
              res_nxt   = uresp.res;
              push_nxt  = 1'b1;
              state_nxt = S_FIN;
            end
            TG_PW_MI: begin
              big_nxt   = big_r | uresp.ovf;
              mag_nxt   = uresp.res;
              state_nxt = S_PW_I1;
            end
            TG_PW_SQ: begin
              sqbig_nxt = sqbig_r | uresp.ovf;
              sq_nxt    = uresp.res;
              state_nxt = S_PW_I0;
            end
            TG_PW_RT: begin
              rt_nxt    = uresp.res;
              state_nxt = S_PW_F1;
            end
            TG_PW_MF: begin
              big_nxt   = big_r | uresp.ovf;
              mag_nxt   = uresp.res;
              state_nxt = S_PW_F2;
            end
            TG_PW_RC: begin
              fix       = sign_fix(uresp.res, neg_r, uresp.ovf);
              res_nxt   = fix[63:0];
              stat_nxt  = fix[64] ? ST_SAT : ST_OK;
              push_nxt  = 1'b1;
              state_nxt = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_RDWAIT: begin
        res_nxt   = ram_rdata;
        state_nxt = S_FIN;
      end

      // integer exponent: square and multiply, low bit first
      S_PW_I0: begin
        if (ip_r == 32'd0) begin
          state_nxt = (frac_r == 32'd0) ? S_PW_E : S_PW_F0;
        end else if (ip_r[0] && !sqbig_r) begin
          ureq.start = 1'b1;
          ureq.op    = UOP_MUL;
          ureq.a     = mag_r;
          ureq.b     = sq_r;
          tag_nxt    = TG_PW_MI;
          state_nxt  = S_UNIT;
        end else begin
          if (ip_r[0]) begin
            big_nxt = 1'b1;
          end
          state_nxt = S_PW_I1;
        end
      end

      S_PW_I1: begin
        ip_nxt = {1'b0, ip_r[31:1]};
        if ((ip_r[31:1] != 31'd0) && !sqbig_r) begin
          ureq.start = 1'b1;
          ureq.op    = UOP_MUL;
          ureq.a     = sq_r;
          ureq.b     = sq_r;
          tag_nxt    = TG_PW_SQ;
          state_nxt  = S_UNIT;
        end else begin
          state_nxt = S_PW_I0;
        end
      end

      // fraction bits, top first: take one more root, multiply on a set bit
      S_PW_F0: begin
        ureq.start = 1'b1;
        ureq.op    = UOP_SQRT;
        ureq.a     = rt_r;
        tag_nxt    = TG_PW_RT;
        state_nxt  = S_UNIT;
      end

      S_PW_F1: begin
        if (frac_r[31]) begin
          ureq.start = 1'b1;
          ureq.op    = UOP_MUL;
          ureq.a     = mag_r;
          ureq.b     = rt_r;
          tag_nxt    = TG_PW_MF;
          state_nxt  = S_UNIT;
        end else begin
          state_nxt = S_PW_F2;
        end
      end

      S_PW_F2: begin
        // drop the bit just used; stop once no set bits remain
        frac_nxt  = {frac_r[30:0], 1'b0};
        state_nxt = (frac_r[30:0] == 31'd0) ? S_PW_E : S_PW_F0;
      end

      S_PW_E: begin
        state_nxt = S_FIN;
        push_nxt  = 1'b1;
        if (!eneg_r) begin
          fix = sign_fix(mag_r, neg_r, big_r);
        end else if (big_r) begin
          fix = sign_fix(64'd0, neg_r, 1'b0);
        end else if (mag_r == 64'd0) begin
          fix = sign_fix(64'd0, neg_r, 1'b1);
        end else begin
          push_nxt   = 1'b0;
          ureq.start = 1'b1;
          ureq.op    = UOP_DIV;
          ureq.a     = Q_ONE;
          ureq.b     = mag_r;
          tag_nxt    = TG_PW_RC;
          state_nxt  = S_UNIT;
        end
        res_nxt  = fix[63:0];
        stat_nxt = fix[64] ? ST_SAT : ST_OK;
      end

      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          if (upd_r || push_r) begin
            acc_nxt = res_r;
          end
          if (push_r) begin
            ram_we = 1'b1;
            if (fill_r < FW'(HISTORY_DEPTH)) begin
              ram_waddr = wrap_addr(SW'(head_r) + SW'(fill_r));
              fill_nxt  = fill_r + FW'(1);
            end else begin
              // full: overwrite the oldest entry and advance the head
              ram_waddr = head_r;
              head_nxt  = wrap_addr(SW'(head_r) + SW'(1));
            end
          end
          if (clrh_r) begin
            fill_nxt = '0;
          end
          cnt_ext                    = CW'(fill_nxt);
          out_data_nxt.current_value = fin_value;
          out_data_nxt.status        = stat_r;
          out_data_nxt.history_count = cnt_ext[3:0];
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      fill_r      <= '0;
      head_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    act_r      <= act_nxt;
    opnd_r     <= opnd_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    push_r     <= push_nxt;
    upd_r      <= upd_nxt;
    clrh_r     <= clrh_nxt;
    neg_r      <= neg_nxt;
    big_r      <= big_nxt;
    sqbig_r    <= sqbig_nxt;
    eneg_r     <= eneg_nxt;
    mag_r      <= mag_nxt;
    sq_r       <= sq_nxt;
    rt_r       <= rt_nxt;
    ip_r       <= ip_nxt;
    frac_r     <= frac_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ACCH_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FW'(HISTORY_DEPTH))
  `ACCH_ASSERT_NEXT(a_acc_hold, clk, rst_n, state_r != S_FIN, $stable(acc_r))
  `ACCH_ASSERT_NOW(a_unit_free, clk, rst_n, ureq.start, !uresp.busy && !uresp.done)
  `ACCH_ASSERT_NEXT(a_out_load, clk, rst_n, (state_r == S_FIN) && (!out_valid_r || !out_stall), out_valid_r && (state_r == S_IDLE))

endmodule

/* verif/acch_checker.sv */
// Checker for the accumulator calculator: predicts each result and compares it.
module acch_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  acch_pkg::acch_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  acch_pkg::acch_out_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import acch_pkg::*;

  localparam int DEPTH = ACCH_HIST_DEPTH;

  logic [63:0] acc_q;
  logic [63:0] hist_q [DEPTH];
  int unsigned hist_fill;
  acch_out_t   expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    acc_q      = '0;
    hist_fill  = 0;
    foreach (hist_q[i]) hist_q[i] = '0;
  end

  // Magnitude product (a*b)>>32; bit 64 flags a value above 2^63.
  function automatic logic [64:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, a} * {64'd0, b};
    r = p[95:32];
    if (p[127:96] != 0 || r > Q_TOP) return {1'b1, Q_TOP};
    return {1'b0, r};
  endfunction

  // Magnitude quotient (n<<32)/d, d nonzero; bit 64 flags overflow.
  function automatic logic [64:0] q_div(logic [63:0] n, logic [63:0] d);
    logic [63:0] rem, q;
    logic        big, bitv;
    rem = '0;
    q   = '0;
    big = 1'b0;
    for (int i = 95; i >= 0; i--) begin
      bitv = (i >= 32) ? n[i-32] : 1'b0;
      rem  = {rem[62:0], bitv};
      if (q[63]) big = 1'b1;
      q = q << 1;
      if (rem >= d) begin
        rem  = rem - d;
        q[0] = 1'b1;
      end
    end
    if (big || q > Q_TOP) return {1'b1, Q_TOP};
    return {1'b0, q};
  endfunction

  // floor(sqrt(x << 32))
  function automatic logic [63:0] q_sqrt(logic [63:0] x);
    logic [63:0]  r, c;
    logic [127:0] sq, target;
    r      = '0;
    target = {32'd0, x, 32'd0};
    for (int b = 47; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= target) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] q_abs(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Apply sign; bit 64 of the return flags saturation.
  function automatic logic [64:0] q_sign(logic [63:0] mag, logic neg, logic big);
    if (neg) begin
      if (big) return {1'b1, Q_TOP};
      return {1'b0, 64'd0 - mag};
    end
    if (big || mag > Q_MAXPOS) return {1'b1, Q_MAXPOS};
    return {1'b0, mag};
  endfunction

  // Power; returns {invalid, sat, value}.
  function automatic logic [65:0] q_pow(logic [63:0] base, logic [63:0] ex);
    logic [63:0] bmag, emag, mag, sq, r;
    logic [31:0] frac, ip;
    logic        big, sqbig, neg;
    logic [64:0] t;
    bmag  = q_abs(base);
    emag  = q_abs(ex);
    frac  = emag[31:0];
    ip    = emag[63:32];
    mag   = Q_ONE;
    sq    = bmag;
    r     = bmag;
    big   = 1'b0;
    sqbig = 1'b0;
    if (base[63] && frac != 0) return {1'b1, 65'd0};
    if (bmag == 0 && ex[63]) return {1'b1, 65'd0};
    neg = base[63] && emag[32];
    while (ip != 0) begin
      if (ip[0]) begin
        if (sqbig) big = 1'b1;
        else begin
          t = q_mul(mag, sq);
          mag = t[63:0];
          big |= t[64];
        end
      end
      ip = ip >> 1;
      if (ip != 0 && !sqbig) begin
        t = q_mul(sq, sq);
        sq = t[63:0];
        sqbig |= t[64];
      end
    end
    for (int k = 31; k >= 0; k--) begin
      r = q_sqrt(r);
      if (frac[k]) begin
        t = q_mul(mag, r);
        mag = t[63:0];
        big |= t[64];
      end
    end
    if (ex[63]) begin
      if (big) begin
        mag = '0;
        big = 1'b0;
      end else if (mag == 0) begin
        big = 1'b1;
      end else begin
        t = q_div(Q_ONE, mag);
        mag = t[63:0];
        big = t[64];
      end
    end
    t = q_sign(mag, neg, big);
    return {1'b0, t};
  endfunction

  // Advance the predicted calculator by one item and return its result.
  function automatic acch_out_t calc_step(acch_in_t it);
    logic [63:0] a, op, r;
    logic [64:0] t;
    logic [65:0] pw;
    logic        sat, done;
    logic [2:0]  st;
    acch_out_t   res;
    a    = acc_q;
    op   = it.operand;
    r    = '0;
    sat  = 1'b0;
    done = 1'b0;
    st   = ST_OK;
    case (it.action)
      ACT_SET: acc_q = op;
      ACT_EQUALS: begin
        r = a;
        done = 1'b1;
      end
      ACT_ADD: begin
        r = a + op;
        if (a[63] == op[63] && r[63] != a[63]) begin
          r = a[63] ? Q_TOP : Q_MAXPOS;
          sat = 1'b1;
        end
        done = 1'b1;
      end
      ACT_SUB: begin
        r = a - op;
        if (a[63] != op[63] && r[63] != a[63]) begin
          r = a[63] ? Q_TOP : Q_MAXPOS;
          sat = 1'b1;
        end
        done = 1'b1;
      end
      ACT_MUL: begin
        t = q_mul(q_abs(a), q_abs(op));
        t = q_sign(t[63:0], (a[63] ^ op[63]) && t[63:0] != 0, t[64]);
        {sat, r} = t;
        done = 1'b1;
      end
      ACT_DIV: begin
        if (op == 0) st = ST_DIV0;
        else begin
          t = q_div(q_abs(a), q_abs(op));
          t = q_sign(t[63:0], (a[63] ^ op[63]) && t[63:0] != 0, t[64]);
          {sat, r} = t;
          done = 1'b1;
        end
      end
      ACT_NEG: begin
        if (a == Q_TOP) begin
          r = Q_MAXPOS;
          sat = 1'b1;
        end else r = 64'd0 - a;
        done = 1'b1;
      end
      ACT_SQRT: begin
        if (a[63]) st = ST_INVALID;
        else begin
          r = q_sqrt(a);
          done = 1'b1;
        end
      end
      ACT_POW: begin
        pw = q_pow(a, op);
        if (pw[65]) st = ST_INVALID;
        else begin
          {sat, r} = pw[64:0];
          done = 1'b1;
        end
      end
      ACT_RECIP: begin
        if (a == 0) st = ST_DIV0;
        else begin
          t = q_div(Q_ONE, q_abs(a));
          t = q_sign(t[63:0], a[63] && t[63:0] != 0, t[64]);
          {sat, r} = t;
          done = 1'b1;
        end
      end
      ACT_RECALL: begin
        if (it.recall_index < hist_fill) acc_q = hist_q[it.recall_index];
        else st = ST_BAD_INDEX;
      end
      ACT_CLEAR: acc_q = '0;
      ACT_CLRH: hist_fill = 0;
      default: ;
    endcase
    if (done) begin
      acc_q = r;
      if (hist_fill < DEPTH) begin
        hist_q[hist_fill] = r;
        hist_fill++;
      end else begin
        for (int i = 1; i < DEPTH; i++) hist_q[i-1] = hist_q[i];
        hist_q[DEPTH-1] = r;
      end
      if (sat) st = ST_SAT;
    end
    res.current_value = acc_q;
    res.status        = st;
    res.history_count = hist_fill[3:0];
    return res;
  endfunction

  always @(posedge clk) begin
    acch_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(calc_step(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: value %h", out_data.current_value);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.current_value !== want.current_value) begin
            $error("current_value: expected %h, got %h",
                   want.current_value, out_data.current_value);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.history_count !== want.history_count) begin
            $error("history_count: expected %0d, got %0d",
                   want.history_count, out_data.history_count);
            fail_count++;
          end
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

/* verif/tb_accumulator_calculator_with_history_core.sv */
// Testbench top for the accumulator calculator: stimulus, stalls and verdict.
module tb_accumulator_calculator_with_history_core;
  import acch_pkg::*;

  localparam int RANDOM_ITEMS = 1280;
  // Power is the longest item; add the long receiver hold-off on top.
  localparam int IDLE_LIMIT   = 40000;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  acch_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  acch_out_t out_data;
  int        fail_count;
  int        pending;

  // Both sides idle at random except while this is set.
  logic      no_idle = 1'b0;

  accumulator_calculator_with_history_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  acch_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off counted here so the
  // block fills up and has to stall its input while items keep coming.
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle == 3000) hold_left <= 500;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      if (rx_cycle == 3000 || hold_left > 1) out_stall <= 1'b1;
      else if (no_idle) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 17);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one item and hold it until accepted; idle first at random.
  task automatic send_item(logic [3:0] act, logic [63:0] op, logic [3:0] idx);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, operand: op, recall_index: idx};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Q32.32 from an integer part.
  function automatic logic [63:0] q_int(int v);
    return {{32{v[31]}}, v[31:0]} << 32;
  endfunction

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 30) v = q_int($urandom_range(40) - 20);
    else if (sel < 60) v = {{32{1'b0}}, $urandom} | ({{48{1'b0}}, 16'($urandom)} << 32);
    else if (sel < 75) v = {$urandom, $urandom};
    else if (sel < 90) v = {32'd0, $urandom};
    else begin
      case ($urandom_range(5))
        0: v = '0;
        1: v = Q_ONE;
        2: v = 64'd0 - Q_ONE;
        3: v = Q_MAXPOS;
        4: v = Q_TOP;
        default: v = 64'd1;
      endcase
    end
    // Give half the plain values a negative sign.
    if (sel < 90 && $urandom_range(1)) v = 64'd0 - v;
    return v;
  endfunction

  // Exponents mostly small so power stays short; a few are wide.
  function automatic logic [63:0] pick_exponent();
    logic [63:0] e;
    if ($urandom_range(19) == 0) return pick_operand();
    e = q_int($urandom_range(6));
    if ($urandom_range(99) < 40) e[31:0] = $urandom;
    if ($urandom_range(3) == 0) e = 64'd0 - e;
    return e;
  endfunction

  function automatic logic [3:0] pick_action();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 14) return ACT_SET;
    if (w < 19) return ACT_EQUALS;
    if (w < 29) return ACT_ADD;
    if (w < 39) return ACT_SUB;
    if (w < 49) return ACT_MUL;
    if (w < 57) return ACT_DIV;
    if (w < 62) return ACT_NEG;
    if (w < 68) return ACT_SQRT;
    if (w < 74) return ACT_POW;
    if (w < 79) return ACT_RECIP;
    if (w < 92) return ACT_RECALL;
    if (w < 95) return ACT_CLEAR;
    if (w < 97) return ACT_CLRH;
    return 4'($urandom_range(15, 13));
  endfunction

  initial begin
    logic [3:0] act;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: saturation at both ends, error cases, every action.
    send_item(ACT_RECALL, '0, 4'd0);             // recall with empty history
    send_item(ACT_SET, Q_MAXPOS, 4'd0);
    send_item(ACT_ADD, 64'd1, 4'd0);             // add overflows high
    send_item(ACT_SET, Q_TOP, 4'd0);
    send_item(ACT_SUB, 64'd1, 4'd0);             // sub overflows low
    send_item(ACT_NEG, '0, 4'd0);                // negate most negative
    send_item(ACT_EQUALS, '0, 4'd0);
    send_item(ACT_DIV, '0, 4'd0);                // divide by zero
    send_item(ACT_CLEAR, '0, 4'd0);
    send_item(ACT_RECIP, '0, 4'd0);              // reciprocal of zero
    send_item(ACT_POW, 64'd0 - Q_ONE, 4'd0);     // zero base, negative exponent
    send_item(ACT_POW, '0, 4'd0);                // zero to the zero is one
    send_item(ACT_SET, q_int(-2), 4'd0);
    send_item(ACT_SQRT, '0, 4'd0);               // root of a negative
    send_item(ACT_POW, q_int(1) | 64'h8000_0000, 4'd0); // negative base, fraction
    send_item(ACT_POW, q_int(3), 4'd0);          // odd power keeps the sign
    send_item(ACT_SET, q_int(2), 4'd0);
    send_item(ACT_POW, q_int(10), 4'd0);
    send_item(ACT_SQRT, '0, 4'd0);
    send_item(ACT_RECIP, '0, 4'd0);
    send_item(ACT_MUL, q_int(3) | 64'h8000_0000, 4'd0);
    send_item(ACT_DIV, 64'd0 - 64'h4000_0000, 4'd0);
    send_item(ACT_RECALL, '0, 4'd15);            // index past the fill
    send_item(ACT_RECALL, '0, 4'd0);
    send_item(ACT_CLRH, '0, 4'd0);
    send_item(4'd13, {$urandom, $urandom}, 4'd9);
    send_item(4'd15, '0, 4'd0);

    // Pause until every result is back before the random part.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Stretch with no idling on either side.
      if (n == 600) no_idle <= 1'b1;
      if (n == 800) no_idle <= 1'b0;
      act = pick_action();
      send_item(act, (act == ACT_POW) ? pick_exponent() : pick_operand(),
                4'($urandom_range(15)));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
